### design/mtbw_pkg.sv
`default_nettype none
package mtbw_pkg;

  localparam int RING_DEPTH_DEF = 4096;
  localparam int WIN_W = 13;
  localparam logic [WIN_W-1:0] WINDOW_RST = 13'd200;
  localparam int Q_BITS = 16;
  localparam logic [Q_BITS-1:0] Q15_MAX = 16'h7fff;
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_WINDOW = 3'd0;

  typedef enum logic [1:0] {
    DIR_FLAT,
    DIR_UP,
    DIR_DOWN
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_ADDR,
    ST_READ,
    ST_BASE,
    ST_START,
    ST_DIV
  } state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_FIN
  } div_state_e;

endpackage
`default_nettype wire

### design/mtbw_ring.sv
`default_nettype none
module mtbw_ring #(
  parameter int DEPTH = mtbw_pkg::RING_DEPTH_DEF,
  parameter int DW    = 26
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### design/mtbw_div.sv
`default_nettype none
module mtbw_div #(
  parameter int CNT_W = 13
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [CNT_W-1:0]            ups_i,
  input  wire logic [CNT_W-1:0]            downs_i,
  output logic                             done_o,
  output logic [mtbw_pkg::Q_BITS-1:0]      quo_o
);

  localparam int QB = mtbw_pkg::Q_BITS;
  localparam int CW = $clog2(QB);

  mtbw_pkg::div_state_e st_q, st_d;

  logic [CNT_W-1:0] r_q, tot_q, diff, rs, rnext;
  logic [QB-1:0]    nlo_q, q_q, res_q;
  logic [CW-1:0]    cnt_q;
  logic             neg_q, zero_q, done_q, ge;
  logic             load_en, step_en, fin_en;

  assign diff  = (ups_i >= downs_i) ? (ups_i - downs_i) : (downs_i - ups_i);
  assign rs    = {r_q[CNT_W-2:0], nlo_q[QB-1]};
  assign ge    = (rs >= tot_q);
  assign rnext = ge ? (rs - tot_q) : rs;

  always_comb begin
    st_d = st_q;
    case (st_q)
      mtbw_pkg::DV_IDLE: begin
        if (start_i) st_d = mtbw_pkg::DV_RUN;
      end
      mtbw_pkg::DV_RUN: begin
        if (cnt_q == '0) st_d = mtbw_pkg::DV_FIN;
      end
      mtbw_pkg::DV_FIN: begin
        st_d = mtbw_pkg::DV_IDLE;
      end
      default: st_d = mtbw_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    load_en = 1'b0;
    step_en = 1'b0;
    fin_en  = 1'b0;
    case (st_q)
      mtbw_pkg::DV_IDLE: load_en = start_i;
      mtbw_pkg::DV_RUN:  step_en = 1'b1;
      mtbw_pkg::DV_FIN:  fin_en  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= mtbw_pkg::DV_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_en) begin
        done_q <= 1'b0;
      end else if (fin_en) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      r_q    <= diff >> 1;
      nlo_q  <= {diff[0], {(QB-1){1'b0}}};
      tot_q  <= ups_i + downs_i;
      neg_q  <= (downs_i > ups_i);
      zero_q <= (ups_i == '0) && (downs_i == '0);
      cnt_q  <= CW'(QB - 1);
      q_q    <= '0;
    end
    if (step_en) begin
      r_q   <= rnext;
      nlo_q <= {nlo_q[QB-2:0], 1'b0};
      q_q   <= {q_q[QB-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
    end
    if (fin_en) begin
      if (zero_q) begin
        res_q <= '0;
      end else if (neg_q) begin
        res_q <= -q_q;
      end else if (q_q[QB-1]) begin
        res_q <= mtbw_pkg::Q15_MAX;
      end else begin
        res_q <= q_q;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule
`default_nettype wire

### design/midprice_tick_bias_window_top.sv
// windowed tick-direction imbalance of the book mid price
// slave stream: one request per book update, tdata = {ask, bid}, tuser = book_valid
// a request with book_valid low is taken while the sequencer is idle and changes nothing
// a valid request classifies bid+ask against the previous sum as up, down or flat,
// stores running up/down totals in the direction ring and reads the totals that
// lie just outside the window, giving the windowed up and down counts
// master stream: bias_q15 = (ups - downs) / (ups + downs), signed q15
// after acceptance the sequencer steps through the span, address, ring read,
// ring write and divider start states, then waits on the restoring divider
// that yields one quotient bit per cycle over 16 bits, then fixes the sign
// tready is high only while the sequencer is idle, so a new update is taken only
// once the previous valid update's result has gone into the output register
// the result waits in an output register; a stalled receiver holds the next
// update in the divider stage until the register frees up
// window_steps sits at apb address 0; it is to be written only while idle, which the
// block does not enforce, and applies from the next valid update
// reset clears the history and sets window_steps to 200; the ring needs no clearing
`default_nettype none
module midprice_tick_bias_window_top #(
  parameter int RING_DEPTH = mtbw_pkg::RING_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [63:0]                  s_axis_tdata,   // bid_price, ask_price
  input  wire logic                         s_axis_tuser,   // book_valid
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [15:0]                       m_axis_tdata,   // bias_q15
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mtbw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CNT_W = AW + 1;
  localparam int WX    = (CNT_W > mtbw_pkg::WIN_W) ? CNT_W : mtbw_pkg::WIN_W;

  mtbw_pkg::state_e st_q, st_d;
  mtbw_pkg::dir_e   dir;

  logic [mtbw_pkg::WIN_W-1:0] window_q;
  logic [32:0]                prev_sum_q, sum;
  logic                       have_prev_q, was_full_q, base_zero_q, base_self_q;
  logic [CNT_W-1:0]           cum_up_q, cum_dn_q, fill_q, span_q, ups_q, dns_q;
  logic [CNT_W-1:0]           base_up, base_dn;
  logic [AW-1:0]              wp_q, raddr_q;
  logic [WX-1:0]              win_x, depth_x, fill_x, win_c, span_x;
  logic [CNT_W:0]             addr_t, addr_w;
  logic [2*CNT_W-1:0]         rdata;
  logic                       ring_re, ring_we, div_start, div_done, out_load;
  logic                       in_take, slot_free, m_valid_q;
  logic [15:0]                m_data_q, quo;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == mtbw_pkg::ADDR_WINDOW) ? 32'(window_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= mtbw_pkg::WINDOW_RST;
    end else if (psel && penable && pwrite && (paddr == mtbw_pkg::ADDR_WINDOW)) begin
      window_q <= pwdata[mtbw_pkg::WIN_W-1:0];
    end
  end

  // step direction
  assign sum = {1'b0, s_axis_tdata[31:0]} + {1'b0, s_axis_tdata[63:32]};
  always_comb begin
    dir = mtbw_pkg::DIR_FLAT;
    if (have_prev_q && (sum > prev_sum_q)) begin
      dir = mtbw_pkg::DIR_UP;
    end else if (have_prev_q && (sum < prev_sum_q)) begin
      dir = mtbw_pkg::DIR_DOWN;
    end
  end

  // window span and baseline address
  assign win_x   = WX'(window_q);
  assign depth_x = WX'(RING_DEPTH);
  assign fill_x  = WX'(fill_q);
  assign win_c   = (win_x > depth_x) ? depth_x : win_x;
  assign span_x  = (win_c > fill_x) ? fill_x : win_c;

  assign addr_t = (CNT_W+1)'(wp_q) + (CNT_W+1)'(RING_DEPTH) - (CNT_W+1)'(span_q);
  assign addr_w = (addr_t >= (CNT_W+1)'(RING_DEPTH)) ? (addr_t - (CNT_W+1)'(RING_DEPTH))
                                                      : addr_t;

  assign base_up = base_self_q ? cum_up_q : (base_zero_q ? '0 : rdata[CNT_W-1:0]);
  assign base_dn = base_self_q ? cum_dn_q : (base_zero_q ? '0 : rdata[2*CNT_W-1:CNT_W]);

  assign slot_free = !m_valid_q || m_axis_tready;
  assign in_take   = s_axis_tvalid && s_axis_tready;

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      mtbw_pkg::ST_IDLE: begin
        if (in_take && s_axis_tuser) st_d = mtbw_pkg::ST_SPAN;
      end
      mtbw_pkg::ST_SPAN:  st_d = mtbw_pkg::ST_ADDR;
      mtbw_pkg::ST_ADDR:  st_d = mtbw_pkg::ST_READ;
      mtbw_pkg::ST_READ:  st_d = mtbw_pkg::ST_BASE;
      mtbw_pkg::ST_BASE:  st_d = mtbw_pkg::ST_START;
      mtbw_pkg::ST_START: st_d = mtbw_pkg::ST_DIV;
      mtbw_pkg::ST_DIV: begin
        if (div_done && slot_free) st_d = mtbw_pkg::ST_IDLE;
      end
      default: st_d = mtbw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ring_re       = 1'b0;
    ring_we       = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (st_q)
      mtbw_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      mtbw_pkg::ST_READ:  ring_re       = 1'b1;
      mtbw_pkg::ST_BASE:  ring_we       = 1'b1;
      mtbw_pkg::ST_START: div_start     = 1'b1;
      mtbw_pkg::ST_DIV:   out_load      = div_done && slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= mtbw_pkg::ST_IDLE;
      prev_sum_q  <= '0;
      have_prev_q <= 1'b0;
      cum_up_q    <= '0;
      cum_dn_q    <= '0;
      fill_q      <= '0;
      was_full_q  <= 1'b0;
      wp_q        <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (in_take && s_axis_tuser) begin
        prev_sum_q  <= sum;
        have_prev_q <= 1'b1;
        was_full_q  <= (fill_q == CNT_W'(RING_DEPTH));
        if (fill_q != CNT_W'(RING_DEPTH)) fill_q <= fill_q + 1'b1;
        if (dir == mtbw_pkg::DIR_UP) cum_up_q <= cum_up_q + 1'b1;
        if (dir == mtbw_pkg::DIR_DOWN) cum_dn_q <= cum_dn_q + 1'b1;
      end
      if (ring_we) begin
        wp_q <= (wp_q == AW'(RING_DEPTH - 1)) ? '0 : (wp_q + 1'b1);
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == mtbw_pkg::ST_SPAN) begin
      span_q      <= span_x[CNT_W-1:0];
      base_self_q <= (span_x == '0);
      base_zero_q <= (span_x == fill_x) && !was_full_q;
    end
    if (st_q == mtbw_pkg::ST_ADDR) begin
      raddr_q <= addr_w[AW-1:0];
    end
    if (ring_we) begin
      ups_q <= cum_up_q - base_up;
      dns_q <= cum_dn_q - base_dn;
    end
    if (out_load) begin
      m_data_q <= quo;
    end
  end

  mtbw_ring #(
    .DEPTH (RING_DEPTH),
    .DW    (2 * CNT_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wp_q),
    .wdata_i ({cum_dn_q, cum_up_q}),
    .re_i    (ring_re),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  mtbw_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .ups_i   (ups_q),
    .downs_i (dns_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire
